// File: src/stdpwd_pkg.sv
package stdpwd_pkg;

    // Window and kernel geometry.
    localparam int WINDOW           = 128;
    localparam int KERNEL_FRAC_BITS = 14;
    localparam int KERNEL_ENTRIES   = 128;
    localparam int KERNEL_W         = KERNEL_FRAC_BITS + 1;
    localparam int KIDX_W           = $clog2(KERNEL_ENTRIES);
    localparam int ADDR_W           = $clog2(WINDOW);
    localparam int BIN_W            = $clog2(WINDOW + 1);

    // Arithmetic widths.
    localparam int LR_W   = 16;
    localparam int SUM_W  = 31;
    localparam int ACC_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + LR_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int OUT_W  = 30;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [LR_W-1:0] LR_RESET = LR_W'(66);
    localparam logic [63:0]     LN2_Q32  = 64'd2977044472;

    typedef logic [KERNEL_W-1:0] t_kernel;

    // Decoded control from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic start;
        logic read;
        logic sat;
        logic mul;
        logic take_abs;
        logic emit;
    } t_ctrl;

    // Condition flags from the datapath back to the sequencer.
    typedef struct packed {
        logic past_win;
        logic scan_more;
        logic last;
        logic out_busy;
    } t_status;

    // Softplus kernel, ln(1 + exp(d/128)), from its Taylor series in Q.32,
    // rounded to KERNEL_FRAC_BITS fraction bits. Evaluated at elaboration only.
    function automatic logic [KERNEL_ENTRIES*KERNEL_W-1:0] build_kernel_rom();
        logic [KERNEL_ENTRIES*KERNEL_W-1:0] rom;
        logic [63:0] pw [0:10];
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        rom = '0;
        for (int d = 0; d < KERNEL_ENTRIES; d++) begin
            pw[0] = 64'd1 << 32;
            for (int k = 1; k <= 10; k++) begin
                pw[k] = (pw[k-1] * 64'(d)) >> 7;
            end
            pos = LN2_Q32 + (pw[1] >> 1) + (pw[2] >> 3) + pw[6] / 64'd2880
                + (64'd31 * pw[10]) / 64'd14515200;
            neg = pw[4] / 64'd192 + (64'd17 * pw[8]) / 64'd645120;
            v   = pos - neg;
            v   = (v + (64'd1 << (31 - KERNEL_FRAC_BITS))) >> (32 - KERNEL_FRAC_BITS);
            rom[d*KERNEL_W +: KERNEL_W] = KERNEL_W'(v);
        end
        return rom;
    endfunction

    localparam logic [KERNEL_ENTRIES*KERNEL_W-1:0] KERNEL_ROM = build_kernel_rom();

endpackage

// File: src/stdp_pair_weight_delta.sv
// Pair-based STDP weight change over one window of time bins. Each input item
// is one bin carrying a presynaptic and a postsynaptic spike bit, with tlast
// marking the final bin. A post spike adds the softplus kernel of its lag to
// every earlier pre spike; a pre spike subtracts the kernel of its lag to
// every post spike at or before it, its own bin included. The running pair
// sum saturates to 31 bits after each bin. On the final bin one result item
// is produced, the pair sum times the unsigned Q0.16 learning rate, rounded
// half away from zero and saturated to 30 bits with 14 fraction bits; the
// window then starts afresh. Bins beyond the 128th of a window are ignored
// apart from their tlast. A small microcoded sequencer steps through the
// work: it takes a bin, walks the history store from the first bin to the
// bin's own, one stored bin per cycle through its single read port, and
// saturates the sum; an ignored bin skips the walk. A final bin multiplies,
// takes the magnitude and emits, waiting if the last result is untaken. A
// result waits in the output register while the next window is processed.
// The learning rate, reset to 66 (about 0.001), must be written through the
// configuration port only while idle; the block does not enforce this.
module stdp_pair_weight_delta (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration: learning rate, unsigned Q0.16.
    input  logic                                   i_cfg_wr_en,
    input  logic [stdpwd_pkg::LR_W-1:0]            i_cfg_wr_data,
    // Input bins.
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Bit 0 pre_spike, bit 1 post_spike, bits 7:2 zero.
    input  logic [stdpwd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    // Weight change results.
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // Bits 29:0 weight_delta (signed), bits 31:30 zero.
    output logic [stdpwd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import stdpwd_pkg::*;

    t_ctrl            ctrl;
    t_status          status;
    logic [OUT_W-1:0] out_data;

    // The sequencer holds the program and decides each cycle which datapath
    // operation runs and where control goes next.
    stdpwd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // The datapath holds the bin histories, the kernel table, the pair-sum
    // accumulator, the learning-rate multiplier and the output register.
    stdpwd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_in_valid    (i_s_axis_tvalid),
        .i_pre         (i_s_axis_tdata[0]),
        .i_post        (i_s_axis_tdata[1]),
        .i_last        (i_s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (status),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (out_data)
    );

    // An item is taken only in the step that waits for the next bin.
    assign o_s_axis_tready = ctrl.accept;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_W)'(0), out_data};

endmodule

// File: src/stdpwd_seq.sv
module stdpwd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  stdpwd_pkg::t_status i_status,
    output stdpwd_pkg::t_ctrl   o_ctrl
);
    import stdpwd_pkg::*;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_PAST_WIN,
        C_SCAN_MORE,
        C_NOT_LAST,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START,
        OP_READ,
        OP_SAT,
        OP_MUL,
        OP_ABS,
        OP_EMIT
    } t_op;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc S_WAIT  = PC_W'(0);
    localparam t_pc S_CHECK = PC_W'(1);
    localparam t_pc S_SCAN  = PC_W'(2);
    localparam t_pc S_DRAIN = PC_W'(3);
    localparam t_pc S_SAT   = PC_W'(4);
    localparam t_pc S_LAST  = PC_W'(5);
    localparam t_pc S_MUL   = PC_W'(6);
    localparam t_pc S_ABS   = PC_W'(7);
    localparam t_pc S_EMIT  = PC_W'(8);
    localparam t_pc S_LOOP  = PC_W'(9);

    // The program. A step jumps to its target when its condition holds and
    // otherwise falls through to the next step.
    function automatic t_uword program_at(t_pc pc);
        t_uword w;
        case (pc)
            S_WAIT:  w = '{op: OP_ACCEPT, cond: C_NO_IN,     target: S_WAIT};
            S_CHECK: w = '{op: OP_START,  cond: C_PAST_WIN,  target: S_LAST};
            S_SCAN:  w = '{op: OP_READ,   cond: C_SCAN_MORE, target: S_SCAN};
            S_DRAIN: w = '{op: OP_NONE,   cond: C_NEVER,     target: S_WAIT};
            S_SAT:   w = '{op: OP_SAT,    cond: C_NEVER,     target: S_WAIT};
            S_LAST:  w = '{op: OP_NONE,   cond: C_NOT_LAST,  target: S_WAIT};
            S_MUL:   w = '{op: OP_MUL,    cond: C_NEVER,     target: S_WAIT};
            S_ABS:   w = '{op: OP_ABS,    cond: C_NEVER,     target: S_WAIT};
            S_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: S_EMIT};
            S_LOOP:  w = '{op: OP_NONE,   cond: C_ALWAYS,    target: S_WAIT};
            default: w = '{op: OP_NONE,   cond: C_ALWAYS,    target: S_WAIT};
        endcase
        return w;
    endfunction

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   take_jump;

    always_comb begin
        uw = program_at(r_pc);
        case (uw.cond)
            C_NEVER:     take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_IN:     take_jump = !i_in_valid;
            C_PAST_WIN:  take_jump = i_status.past_win;
            C_SCAN_MORE: take_jump = i_status.scan_more;
            C_NOT_LAST:  take_jump = !i_status.last;
            C_OUT_BUSY:  take_jump = i_status.out_busy;
            default:     take_jump = 1'b1;
        endcase
        n_pc = take_jump ? uw.target : r_pc + 1'b1;

        o_ctrl          = '0;
        o_ctrl.accept   = (uw.op == OP_ACCEPT);
        o_ctrl.start    = (uw.op == OP_START) && !i_status.past_win;
        o_ctrl.read     = (uw.op == OP_READ);
        o_ctrl.sat      = (uw.op == OP_SAT);
        o_ctrl.mul      = (uw.op == OP_MUL);
        o_ctrl.take_abs = (uw.op == OP_ABS);
        o_ctrl.emit     = (uw.op == OP_EMIT) && !i_status.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: src/stdpwd_dpath.sv
module stdpwd_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stdpwd_pkg::t_ctrl              i_ctrl,
    input  logic                           i_in_valid,
    input  logic                           i_pre,
    input  logic                           i_post,
    input  logic                           i_last,
    input  logic                           i_cfg_wr_en,
    input  logic [stdpwd_pkg::LR_W-1:0]    i_cfg_wr_data,
    input  logic                           i_out_ready,
    output stdpwd_pkg::t_status            o_status,
    output logic                           o_out_valid,
    output logic [stdpwd_pkg::OUT_W-1:0]   o_out_data
);
    import stdpwd_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_SUM_MAX = ACC_W'((2 ** (SUM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_SUM_MIN = -ACC_W'(2 ** (SUM_W - 1));
    localparam int                      RND_W       = MAG_W - LR_W;
    localparam logic [RND_W-1:0]        OUT_LIM     = RND_W'(2 ** (OUT_W - 1));
    localparam logic [OUT_W-1:0]        OUT_MAX     = OUT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic [OUT_W-1:0]        OUT_MIN     = OUT_W'(2 ** (OUT_W - 1));
    localparam logic [MAG_W-1:0]        RND_HALF    = MAG_W'(2 ** (LR_W - 1));

    // History store, one entry per bin: bit 1 post spike, bit 0 pre spike.
    logic [1:0]               r_hist [WINDOW];
    logic [1:0]               r_hist_q;

    logic [LR_W-1:0]          r_lr;
    logic                     r_cur_pre;
    logic                     r_cur_post;
    logic                     r_cur_last;
    logic [BIN_W-1:0]         r_bin;
    logic [ADDR_W-1:0]        r_j;
    logic                     r_rd_valid;
    logic                     r_rd_self;
    t_kernel                  r_kern;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  r_pair_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;

    logic [ADDR_W-1:0]        t_addr;
    logic [ADDR_W-1:0]        lag;
    logic [KIDX_W-1:0]        kidx;
    logic                     add_k;
    logic                     sub_k;
    logic signed [ACC_W-1:0]  kern_ext;
    logic signed [SUM_W-1:0]  sat_sum;
    logic [MAG_W-1:0]         rnd_sum;
    logic [RND_W-1:0]         rnd;
    logic [OUT_W-1:0]         n_out_data;

    always_comb begin
        t_addr = r_bin[ADDR_W-1:0];
        lag    = t_addr - r_j;
        if (int'(lag) >= KERNEL_ENTRIES) begin
            kidx = KIDX_W'(KERNEL_ENTRIES - 1);
        end else begin
            kidx = KIDX_W'(lag);
        end

        // A pre spike in the current bin itself is not added for its post; that pair subtracts.
        add_k    = r_cur_post && r_hist_q[0] && !r_rd_self;
        sub_k    = r_cur_pre && r_hist_q[1];
        kern_ext = $signed(ACC_W'(r_kern));

        if (r_acc > ACC_SUM_MAX) begin
            sat_sum = SUM_W'(ACC_SUM_MAX);
        end else if (r_acc < ACC_SUM_MIN) begin
            sat_sum = SUM_W'(ACC_SUM_MIN);
        end else begin
            sat_sum = SUM_W'(r_acc);
        end

        rnd_sum = r_mag + RND_HALF;
        rnd     = rnd_sum[MAG_W-1:LR_W];
        if (r_neg) begin
            n_out_data = (rnd > OUT_LIM) ? OUT_MIN : OUT_W'(-rnd);
        end else begin
            n_out_data = (rnd > OUT_LIM - 1'b1) ? OUT_MAX : OUT_W'(rnd);
        end

        o_status.past_win  = (r_bin >= BIN_W'(WINDOW));
        o_status.scan_more = (r_j != t_addr);
        o_status.last      = r_cur_last;
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_hist[t_addr] <= {r_cur_post, r_cur_pre};
        end
        if (i_ctrl.read) begin
            r_hist_q <= r_hist[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr        <= LR_RESET;
            r_bin       <= '0;
            r_pair_sum  <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lr <= i_cfg_wr_data;
            end
            r_rd_valid <= i_ctrl.read;
            if (i_ctrl.sat) begin
                r_pair_sum <= sat_sum;
                r_bin      <= r_bin + 1'b1;
            end
            if (i_ctrl.emit) begin
                r_pair_sum  <= '0;
                r_bin       <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && i_in_valid) begin
            r_cur_pre  <= i_pre;
            r_cur_post <= i_post;
            r_cur_last <= i_last;
        end
        if (i_ctrl.start) begin
            r_j   <= '0;
            r_acc <= ACC_W'(r_pair_sum);
        end
        if (i_ctrl.read) begin
            r_j       <= r_j + 1'b1;
            r_rd_self <= (r_j == t_addr);
            r_kern    <= KERNEL_ROM[kidx*KERNEL_W +: KERNEL_W];
        end
        if (r_rd_valid) begin
            if (add_k && !sub_k) begin
                r_acc <= r_acc + kern_ext;
            end else if (sub_k && !add_k) begin
                r_acc <= r_acc - kern_ext;
            end
        end
        if (i_ctrl.mul) begin
            r_prod <= r_pair_sum * $signed({1'b0, r_lr});
        end
        if (i_ctrl.take_abs) begin
            r_neg <= r_prod[PROD_W-1];
            r_mag <= r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        end
        if (i_ctrl.emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: bench/stdp_weight_delta_checker.sv
module stdp_weight_delta_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [stdpwd_pkg::LR_W-1:0]        i_cfg_wr_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [stdpwd_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                               i_in_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [stdpwd_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                                 o_failures,
    output int                                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import stdpwd_pkg::*;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));
    localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO = -(longint'(1) <<< (OUT_W - 1));

    longint                  softplus_tab [KERNEL_ENTRIES];
    bit [WINDOW-1:0]         pre_seen;
    bit [WINDOW-1:0]         post_seen;
    int                      bins_taken;
    longint                  pair_total;
    logic [LR_W-1:0]         rate;
    logic signed [OUT_W-1:0] delta_q [$];
    logic signed [OUT_W-1:0] want_delta;
    int                      failures = 0;

    // Softplus table from its Taylor series in Q.32, rounded to the kernel width.
    initial begin
        bit [63:0] pw [0:10];
        bit [63:0] up;
        bit [63:0] down;
        bit [63:0] q;
        for (int d = 0; d < KERNEL_ENTRIES; d++) begin
            pw[0] = 64'd1 << 32;
            for (int k = 1; k <= 10; k++)
                pw[k] = (pw[k-1] * 64'(d)) >> 7;
            up   = LN2_Q32 + (pw[1] >> 1) + (pw[2] >> 3) + pw[6] / 64'd2880
                 + (64'd31 * pw[10]) / 64'd14515200;
            down = pw[4] / 64'd192 + (64'd17 * pw[8]) / 64'd645120;
            q    = up - down;
            q    = (q + (64'd1 << (31 - KERNEL_FRAC_BITS))) >> (32 - KERNEL_FRAC_BITS);
            softplus_tab[d] = longint'(q);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: weight delta check: %s", $time, msg);
        failures++;
    endtask

    // Folds one time bin into the running pair sum and queues a weight
    // change when the bin closes the window.
    task automatic accumulate_bin(input bit pre, input bit post, input bit last);
        int     t;
        int     lag;
        longint acc;
        longint prod;
        longint mag;
        longint val;
        bit     negative;
        if (bins_taken < WINDOW) begin
            t   = bins_taken;
            acc = pair_total;
            pre_seen[t]  = pre;
            post_seen[t] = post;
            if (post) begin
                for (int j = 0; j < t; j++) begin
                    lag = (t - j >= KERNEL_ENTRIES) ? KERNEL_ENTRIES - 1 : t - j;
                    if (pre_seen[j])
                        acc += softplus_tab[lag];
                end
            end
            if (pre) begin
                for (int j = 0; j <= t; j++) begin
                    lag = (t - j >= KERNEL_ENTRIES) ? KERNEL_ENTRIES - 1 : t - j;
                    if (post_seen[j])
                        acc -= softplus_tab[lag];
                end
            end
            if (acc > SUM_HI)
                acc = SUM_HI;
            if (acc < SUM_LO)
                acc = SUM_LO;
            pair_total = acc;
            bins_taken = t + 1;
        end
        if (last) begin
            prod     = pair_total * longint'(rate);
            negative = prod < 0;
            mag      = negative ? -prod : prod;
            mag      = (mag + 32768) >>> 16;
            val      = negative ? -mag : mag;
            if (val > OUT_HI)
                val = OUT_HI;
            if (val < OUT_LO)
                val = OUT_LO;
            delta_q.insert(delta_q.size(), val[OUT_W-1:0]);
            bins_taken = 0;
            pre_seen   = '0;
            post_seen  = '0;
            pair_total = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate       = LR_RESET;
            bins_taken = 0;
            pre_seen   = '0;
            post_seen  = '0;
            pair_total = 0;
            delta_q.delete();
        end else begin
            if (i_cfg_wr_en)
                rate = i_cfg_wr_data;
            if (i_out_valid === 1'b1 && i_out_ready) begin
                if (delta_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none pending",
                                              $signed(i_out_data[OUT_W-1:0])));
                end else begin
                    want_delta = delta_q.pop_front();
                    if (i_out_data[OUT_W-1:0] !== want_delta)
                        report_mismatch($sformatf("weight_delta %0d, wanted %0d",
                                                  $signed(i_out_data[OUT_W-1:0]),
                                                  want_delta));
                    if (i_out_data[OUT_TDATA_W-1:OUT_W] !== '0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  i_out_data[OUT_TDATA_W-1:OUT_W]));
                end
            end
            if (i_in_valid && i_in_ready === 1'b1)
                accumulate_bin(i_in_data[0], i_in_data[1], i_in_last);
        end
        o_outstanding <= delta_q.size();
        o_failures    <= failures;
    end

endmodule

// File: bench/tb_top.sv
// Top of the bench for the pair-based STDP weight change block. It makes the
// clock, the single reset and all stimulus, and gives the verdict. Prediction
// and comparison live in the checker, which watches both streams and the
// configuration port from beside the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stdpwd_pkg::*;

    // The longest bin walks the whole history store, and this many quiet
    // cycles is ample for the block to settle.
    localparam int SETTLE_CYCLES = 200;
    // At least this many random items are sent in each phase, six phases in all.
    localparam int PHASE_ITEMS   = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [LR_W-1:0]        cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int failures;
    int outstanding;

    // Percentages of cycles in which the sender and the receiver hold back.
    int send_idle = 7;
    int recv_idle = 84;

    stdp_pair_weight_delta DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    stdp_weight_delta_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_last     (s_tlast),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // The receiver decides afresh at every edge whether it will take a
    // result item, so its stalls fall on every phase of the block's work.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Offers one bin and returns at the edge where it is accepted. The valid
    // is left high so that a following bin can be presented straight away;
    // it only drops for a random gap or when sending stops.
    task automatic send_bin(input bit pre, input bit post, input bit last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 2){1'b0}}, post, pre};
        s_tlast  <= last;
        @(posedge i_clk);
        while (s_tready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Lets every pending weight change come out and the block settle, then
    // writes a new learning rate while the block is idle.
    task automatic set_rate(input logic [LR_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One window of random spikes. Most windows are short; some run to the
    // full window and a little past it, so that the longest lags and the
    // ignored bins beyond the window are reached. A long window sometimes
    // carries only a pre spike in its first bin and a post spike in its
    // last counted bin, giving the longest lag on its own.
    task automatic send_random_window(input int len);
        int density_steps [5] = '{0, 10, 50, 90, 100};
        int pre_pct;
        int post_pct;
        bit ends_only;
        bit pre;
        bit post;
        pre_pct   = density_steps[$urandom_range(4)];
        post_pct  = density_steps[$urandom_range(4)];
        ends_only = (len >= WINDOW) && ($urandom_range(2) == 0);
        for (int i = 0; i < len; i++) begin
            if (ends_only) begin
                pre  = (i == 0);
                post = (i == WINDOW - 1);
            end else begin
                pre  = ($urandom_range(99) < pre_pct);
                post = ($urandom_range(99) < post_pct);
            end
            send_bin(pre, post, i == len - 1);
        end
    endtask

    initial begin
        int phase_items;
        int len;
        int pick;
        logic [LR_W-1:0] next_rate;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run at the learning rate left by reset.
        // An empty window gives a zero weight change.
        send_bin(1'b0, 1'b0, 1'b1);
        // Pre and post in one bin form a pair of lag zero, which subtracts.
        send_bin(1'b1, 1'b1, 1'b1);
        // Pre before post adds the kernel of lag one.
        send_bin(1'b1, 1'b0, 1'b0);
        send_bin(1'b0, 1'b1, 1'b1);
        // Post before pre subtracts it.
        send_bin(1'b0, 1'b1, 1'b0);
        send_bin(1'b1, 1'b0, 1'b1);
        // A pre spike meets both an earlier post and the post in its own bin.
        send_bin(1'b0, 1'b1, 1'b0);
        send_bin(1'b1, 1'b1, 1'b1);
        // Every bin spiking on both sides.
        for (int i = 0; i < 8; i++)
            send_bin(1'b1, 1'b1, i == 7);
        // Windows with spikes on one side only produce no pairs.
        for (int i = 0; i < 4; i++)
            send_bin(1'b1, 1'b0, i == 3);
        for (int i = 0; i < 3; i++)
            send_bin(1'b0, 1'b1, i == 2);

        // Random part in six phases. The learning rate changes before each
        // phase, the extremes among the settings, and the idling pattern
        // moves from a slow receiver to a slow sender and then to none.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       next_rate = '1;
                1:       next_rate = '0;
                2:       next_rate = LR_W'(1);
                4:       next_rate = LR_W'(1) << (LR_W - 1);
                default: next_rate = LR_W'($urandom_range(65535));
            endcase
            set_rate(next_rate);
            if (phase < 2) begin
                send_idle = 7;
                recv_idle = 84;
            end else if (phase < 4) begin
                send_idle = 84;
                recv_idle = 7;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    len = $urandom_range(24, 1);
                else if (pick < 92)
                    len = $urandom_range(WINDOW - 1, 25);
                else
                    len = $urandom_range(WINDOW + 12, WINDOW);
                send_random_window(len);
                phase_items += len;
            end
        end

        // Drain: wait for the last weight changes, then watch a while longer
        // so that a stray result item would still be caught.
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failures == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
